[sv/fsla_pkg.sv]
// Shared types and codes for the fixed-slot free-list allocator.
package fsla_pkg;

  localparam int SLOT_W  = 8;
  localparam int LIMIT_W = 9;
  localparam int STAT_W  = 2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_GRANTED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED  = 2'd2;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic              release_null;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic head_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic pop_sel;
  } dp_stat_t;

endpackage

[sv/fsla_ctrl.sv]
// Controller state machine: accepts transactions and sequences free-list pops.
module fsla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fsla_pkg::dp_stat_t   dp_stat,
  output fsla_pkg::ctrl_cmd_t  ctrl_cmd
);
  import fsla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   idle;

  assign idle            = (state_r == S_IDLE);
  assign in_stall        = !idle || dp_stat.out_busy;
  assign ctrl_cmd.accept = idle && in_valid && !dp_stat.out_busy;
  assign ctrl_cmd.head_load = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctrl_cmd.accept && dp_stat.pop_sel) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/fsla_dp.sv]
// Datapath: link memory, free-list head, bump counter, limit and result register.
module fsla_dp #(
  parameter int NUM_SLOTS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsla_pkg::in_t        in_data,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  input  fsla_pkg::ctrl_cmd_t  ctrl_cmd,
  output fsla_pkg::dp_stat_t   dp_stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fsla_pkg::out_t       out_data
);
  import fsla_pkg::*;

  localparam int MEM_DEPTH = (NUM_SLOTS < (1 << SLOT_W)) ? NUM_SLOTS : (1 << SLOT_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [LIMIT_W-1:0] CAP = LIMIT_W'(MEM_DEPTH);

  logic [SLOT_W:0]        link_mem [MEM_DEPTH];
  logic [SLOT_W:0]        link_rd_r;

  logic [LIMIT_W-1:0]     slot_limit_r;
  logic [SLOT_W-1:0]      free_head_r;
  logic                   nonempty_r;
  logic [LIMIT_W-1:0]     fresh_count_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  logic [LIMIT_W-1:0]     limit;
  logic                   is_alloc;
  logic                   fresh_ok;
  logic                   rel_do;

  assign limit    = (slot_limit_r > CAP) ? CAP : slot_limit_r;
  assign is_alloc = (in_data.command == CMD_ALLOC);
  assign fresh_ok = (fresh_count_r < limit);
  assign rel_do   = !is_alloc && !in_data.release_null
                    && ({1'b0, in_data.slot} < CAP);

  assign dp_stat.pop_sel  = is_alloc && nonempty_r;
  assign dp_stat.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    link_rd_r <= link_mem[free_head_r[AW-1:0]];
    if (ctrl_cmd.accept && rel_do) begin
      link_mem[in_data.slot[AW-1:0]] <= {nonempty_r, free_head_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r  <= 9'd256;
      free_head_r   <= '0;
      nonempty_r    <= 1'b0;
      fresh_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_limit_r <= cfg_data;
      end
      if (ctrl_cmd.head_load) begin
        free_head_r <= link_rd_r[SLOT_W-1:0];
        nonempty_r  <= link_rd_r[SLOT_W];
      end else if (ctrl_cmd.accept && rel_do) begin
        free_head_r <= in_data.slot;
        nonempty_r  <= 1'b1;
      end
      if (ctrl_cmd.accept && is_alloc && !nonempty_r && fresh_ok) begin
        fresh_count_r <= fresh_count_r + 1'b1;
      end
      if (ctrl_cmd.accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.accept) begin
      if (!is_alloc) begin
        out_data_r <= '{granted_slot: '0, status: ST_RELEASED};
      end else if (nonempty_r) begin
        out_data_r <= '{granted_slot: free_head_r, status: ST_GRANTED};
      end else if (fresh_ok) begin
        out_data_r <= '{granted_slot: fresh_count_r[SLOT_W-1:0], status: ST_GRANTED};
      end else begin
        out_data_r <= '{granted_slot: '0, status: ST_EXHAUSTED};
      end
    end
  end

endmodule

[sv/fixed_slot_free_list_allocator.sv]
// Top level of the fixed-slot free-list allocator.
//
// Input channel (in_valid, in_stall, in_data): one allocate or release
// transaction per accept. Result channel (out_valid, out_stall, out_data):
// exactly one result per input transaction, in order.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes slot_limit;
// cfg_ready is always high; writes are to be made only while the block is idle, which the
// block itself does not enforce. The result is registered and shown in the cycle after the
// input is accepted. A release, a fresh grant or an exhausted reply leaves the controller idle,
// ready for the next accept. An allocate that pops the free list passes through S_READ, where
// in_stall is high and the registered read of the link memory yields the next head.
// A result waiting under out_stall does not block the next accept once it is
// taken in the same cycle; while it stays stalled, in_stall is held high.
// Reset (rst_n low, synchronous): free list empty, bump counter zero,
// slot_limit 256, no result pending. The link memory is not cleared; an
// entry is only read after a release has written it.
module fixed_slot_free_list_allocator #(
  parameter int NUM_SLOTS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fsla_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fsla_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [8:0]      cfg_data
);
  import fsla_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  assign cfg_ready = 1'b1;

  fsla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .ctrl_cmd (ctrl_cmd)
  );

  fsla_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ctrl_cmd  (ctrl_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sv/fsla_chk.sv]
// Port-level assertions for the fixed-slot free-list allocator, with bind.
module fsla_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input fsla_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_stall,
  input fsla_pkg::out_t  out_data,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input logic [8:0]      cfg_data
);
  import fsla_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_RELEASE
    |=> out_valid && out_data.status == ST_RELEASED && out_data.granted_slot == '0)
    else $error("release transaction gave wrong result");

  a_alloc_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_ALLOC
    |=> out_valid && (out_data.status == ST_GRANTED
                      || (out_data.status == ST_EXHAUSTED && out_data.granted_slot == '0)))
    else $error("allocate transaction gave wrong result");

endmodule

bind fixed_slot_free_list_allocator fsla_chk u_fsla_chk (.*);

[test/fixed_slot_free_list_allocator_test.sv]
// Self-checking testbench for the fixed-slot free-list allocator: directed, fill and random tests.
module fixed_slot_free_list_allocator_test;
  import fsla_pkg::*;

  localparam int POOL_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data;

  logic [SLOT_W-1:0]   next_slot [POOL_DEPTH];
  bit                  next_ok [POOL_DEPTH];
  logic [SLOT_W-1:0]   list_head;
  bit                  list_nonempty;
  logic [LIMIT_W-1:0]  fresh_count;
  logic [LIMIT_W-1:0]  pool_limit;

  out_t                pending_results [$];
  logic [SLOT_W-1:0]   held_slots [$];
  out_t                last_prediction;
  bit                  steady = 1'b0;
  int                  hold_left = 0;
  int                  fail_count = 0;
  int                  cycle_count = 0;

  fixed_slot_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t pool_apply(input in_t t);
    out_t               r;
    logic [LIMIT_W-1:0] cap;
    logic [SLOT_W-1:0]  h;
    cap = (pool_limit > 9'd256) ? 9'd256 : pool_limit;
    r.granted_slot = '0;
    if (t.command == CMD_ALLOC) begin
      if (list_nonempty) begin
        h = list_head;
        list_head = next_slot[h];
        list_nonempty = next_ok[h];
        r.granted_slot = h;
        r.status = ST_GRANTED;
      end else if (fresh_count < cap) begin
        r.granted_slot = fresh_count[SLOT_W-1:0];
        fresh_count = fresh_count + 1'b1;
        r.status = ST_GRANTED;
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else begin
      if (!t.release_null) begin
        next_slot[t.slot] = list_head;
        next_ok[t.slot] = list_nonempty;
        list_head = t.slot;
        list_nonempty = 1'b1;
      end
      r.status = ST_RELEASED;
    end
    return r;
  endfunction

  function automatic in_t alloc_cmd();
    in_t t;
    t.command = CMD_ALLOC;
    t.slot = SLOT_W'($urandom_range(255));
    t.release_null = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic in_t release_cmd(input logic [SLOT_W-1:0] s, input logic nul);
    in_t t;
    t.command = CMD_RELEASE;
    t.slot = s;
    t.release_null = nul;
    return t;
  endfunction

  function automatic in_t pick_transaction(input bit unchecked);
    in_t t;
    int  r;
    t = alloc_cmd();
    r = $urandom_range(99);
    if (r < 40 && held_slots.size() > 0) begin
      t = release_cmd(held_slots[$urandom_range(held_slots.size() - 1)], 1'b0);
    end else if (r >= 88) begin
      t.command = CMD_RELEASE;
      if (!unchecked) begin
        t.release_null = 1'b1;
      end
    end
    return t;
  endfunction

  task automatic offer_transaction(input in_t t);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = t;
    do @(posedge clk); while (in_stall !== 1'b0);
    last_prediction = pool_apply(t);
    pending_results = {pending_results, last_prediction};
    if (t.command == CMD_ALLOC && last_prediction.status == ST_GRANTED) begin
      held_slots = {held_slots, last_prediction.granted_slot};
    end else if (t.command == CMD_RELEASE && !t.release_null) begin
      for (int i = held_slots.size() - 1; i >= 0; i--) begin
        if (held_slots[i] == t.slot) begin
          held_slots.delete(i);
        end
      end
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_slot_limit(input logic [LIMIT_W-1:0] v);
    stop_input();
    wait_results_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pool_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input logic [LIMIT_W-1:0] lim, input int count, input bit unchecked);
    write_slot_limit(lim);
    repeat (count) offer_transaction(pick_transaction(unchecked));
  endtask

  task automatic test_basic_ops();
    repeat (3) offer_transaction(alloc_cmd());
    offer_transaction(release_cmd(8'd1, 1'b0));
    offer_transaction(release_cmd(8'd0, 1'b0));
    offer_transaction(alloc_cmd());
    offer_transaction(alloc_cmd());
    offer_transaction(release_cmd(8'hFF, 1'b1));
    offer_transaction('{command: CMD_ALLOC, slot: 8'hFF, release_null: 1'b1});
    offer_transaction(release_cmd(8'd2, 1'b0));
    offer_transaction(alloc_cmd());
  endtask

  task automatic test_limit_extremes();
    write_slot_limit(9'd0);
    offer_transaction(alloc_cmd());
    offer_transaction(release_cmd(8'd200, 1'b0));
    offer_transaction(alloc_cmd());
    offer_transaction(alloc_cmd());
    write_slot_limit(9'd1);
    offer_transaction(alloc_cmd());
    write_slot_limit(9'd511);
    offer_transaction(alloc_cmd());
    offer_transaction(alloc_cmd());
  endtask

  task automatic test_random_small_limit();
    run_random(LIMIT_W'($urandom_range(64, 8)), 350, 1'b0);
  endtask

  task automatic test_fill_and_drain();
    int guard;
    write_slot_limit(9'd256);
    hold_left = 200;
    guard = 0;
    do begin
      offer_transaction(alloc_cmd());
      guard++;
    end while (last_prediction.status != ST_EXHAUSTED && guard < 600);
    steady = 1'b1;
    while (held_slots.size() > 0) begin
      offer_transaction(release_cmd(held_slots[$urandom_range(held_slots.size() - 1)], 1'b0));
    end
    steady = 1'b0;
  endtask

  task automatic test_random_open_limit();
    run_random(9'd511, 400, 1'b0);
  endtask

  task automatic test_unchecked_release();
    logic [SLOT_W-1:0] s;
    offer_transaction(alloc_cmd());
    s = last_prediction.granted_slot;
    offer_transaction(release_cmd(s, 1'b0));
    offer_transaction(release_cmd(s, 1'b0));
    repeat (3) offer_transaction(alloc_cmd());
  endtask

  task automatic test_random_noise();
    run_random(LIMIT_W'($urandom_range(511)), 350, 1'b1);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !steady && ($urandom_range(99) < 32);
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("%0t: unexpected result, expected none, actual slot %0d status %0d",
                   $time, out_data.granted_slot, out_data.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted_slot !== want.granted_slot) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: granted_slot mismatch, expected %0d, actual %0d",
                     $time, want.granted_slot, out_data.granted_slot);
          end
        end
        if (out_data.status !== want.status) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
        end
      end
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pool_limit = 9'd256;
    fresh_count = '0;
    list_head = '0;
    list_nonempty = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_basic_ops();
    test_limit_extremes();
    test_random_small_limit();
    test_fill_and_drain();
    test_random_open_limit();
    test_unchecked_release();
    test_random_noise();
    stop_input();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
